FILE: rtl/core/dpn_pkg.sv
// ============================================================================
// dpn_pkg - shared types and constants for the depth back-projection core
// Stage numbering, pipeline control struct, register indexes, reset values
// and the reciprocal constants used for the divisions by constants.
// ============================================================================
`default_nettype none

package dpn_pkg;

  // Field widths.
  localparam int PIX_W   = 12;
  localparam int DEPTH_W = 16;
  localparam int COLOR_W = 8;
  localparam int INV_W   = 24;
  localparam int CTR_W   = 20;
  localparam int COORD_W = 32;
  localparam int Z_W     = 23;
  localparam int NRM_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // Pipeline stages, in order from input to output register.
  localparam int NSTAGE   = 8;
  localparam int ST_IN    = 0;  // offset magnitude, sign, normal magnitude
  localparam int ST_MUL1  = 1;  // offset times reciprocal focal length
  localparam int ST_MUL2  = 2;  // times depth
  localparam int ST_RND   = 3;  // rounding offset, drop 16 bits, saturation test
  localparam int ST_DIVH  = 4;  // upper quotient digit by 1000
  localparam int ST_REMH  = 5;  // upper remainder joined with lower bits
  localparam int ST_DIVL  = 6;  // lower quotient by 1000
  localparam int ST_OUT   = 7;  // sign and saturation, output register

  // Per-stage load enables, one bit per stage register.
  typedef struct packed {
    logic [NSTAGE-1:0] load;
  } dpn_ctl_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INV_FX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_X  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_Y  = 2'd3;

  // Register values after reset.
  localparam logic [INV_W-1:0] RST_INV_FX = 24'd28796;
  localparam logic [INV_W-1:0] RST_INV_FY = 24'd28793;
  localparam logic [CTR_W-1:0] RST_CTR_X  = 20'd80139;
  localparam logic [CTR_W-1:0] RST_CTR_Y  = 20'd61042;

  // Half of 1000 * 65536, added before the scaling division.
  localparam logic [60:0] COORD_ROUND = 61'd32768000;
  // Quotient by 1000 reaches 2^31 at this value of the shifted sum.
  localparam logic [44:0] SAT_LIM     = 45'd2147483648000;
  // ceil(2^40 / 1000): exact floor division by 1000 below 2^30.
  localparam logic [30:0] RECIP_1000  = 31'd1099511628;
  localparam logic [21:0] DIV_1000    = 22'd1000;
  // ceil(2^42 / 1000): depth * 65536 / 1000 as depth * this >> 26.
  localparam logic [32:0] Z_RECIP     = 33'd4398046512;
  // ceil(2^23 / 255): exact floor division by 255 below 2^15.
  localparam logic [15:0] NRM_RECIP   = 16'd32897;
  localparam logic [14:0] NRM_HALF    = 15'd127;

endpackage

`default_nettype wire

FILE: rtl/core/dpn_ctrl.sv
// ============================================================================
// dpn_ctrl - valid bits and load enables of the processing pipeline
// Each stage loads when it is empty or when its successor loads, so bubbles
// collapse and input beats keep flowing while the output beat waits.
// ============================================================================
`default_nettype none

module dpn_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_nz,
  input  wire logic              out_stall,
  output logic                   in_stall,
  output logic                   out_valid,
  output dpn_pkg::dpn_ctl_t      ctl
);

  logic [dpn_pkg::NSTAGE-1:0] v_r;
  logic [dpn_pkg::NSTAGE-1:0] v_nxt;
  logic [dpn_pkg::NSTAGE-1:0] rdy;

  // Ready chain from the output register back to the input.
  always_comb begin
    rdy[dpn_pkg::ST_OUT] = !v_r[dpn_pkg::ST_OUT] || !out_stall;
    for (int k = dpn_pkg::ST_OUT - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  // Valid bits move with the data; a zero-depth beat enters as a bubble.
  always_comb begin
    v_nxt = v_r;
    if (rdy[dpn_pkg::ST_IN]) begin
      v_nxt[dpn_pkg::ST_IN] = in_valid && in_nz;
    end
    for (int k = 1; k < dpn_pkg::NSTAGE; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[dpn_pkg::ST_IN];
  assign out_valid = v_r[dpn_pkg::ST_OUT];
  assign ctl.load  = rdy;

  // An accepted beat with depth enters the first stage.
  a_nz_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_nz) |=> v_r[dpn_pkg::ST_IN])
    else $error("accepted pixel with depth did not enter the pipeline");

  // An accepted zero-depth beat leaves no item behind.
  a_zero_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_nz) |=> !v_r[dpn_pkg::ST_IN])
    else $error("zero-depth pixel produced an item");

  // The input only stalls when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled while a pipeline stage was empty");

  // A middle stage keeps its item while its successor cannot take it.
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[dpn_pkg::ST_DIVH] && !rdy[dpn_pkg::ST_REMH]) |=> v_r[dpn_pkg::ST_DIVH])
    else $error("item lost in the division stages");

endmodule

`default_nettype wire

FILE: rtl/core/dpn_proj.sv
// ============================================================================
// dpn_proj - one coordinate lane of the back-projection
// Computes round(d * inv * depth / 65536000) with d = pix * 256 - center,
// saturated to signed 32 bits, over eight register stages.
// ============================================================================
`default_nettype none

module dpn_proj (
  input  wire logic                               clk,
  input  wire dpn_pkg::dpn_ctl_t                  ctl,
  input  wire logic [dpn_pkg::PIX_W-1:0]          pix,
  input  wire logic [dpn_pkg::CTR_W-1:0]          center,
  input  wire logic [dpn_pkg::INV_W-1:0]          inv,
  input  wire logic [dpn_pkg::DEPTH_W-1:0]        depth,
  output logic signed [dpn_pkg::COORD_W-1:0]      point
);

  logic [dpn_pkg::ST_DIVL:dpn_pkg::ST_IN]  neg_r;
  logic [dpn_pkg::ST_DIVL:dpn_pkg::ST_RND] sat_r;

  logic [19:0] pos;
  logic [19:0] mag_nxt;
  logic        neg_nxt;
  logic [19:0] mag_r;
  logic [15:0] dep_r;
  logic [15:0] dep1_r;
  logic [43:0] p1_r;
  logic [59:0] prod_r;
  logic [60:0] rnd;
  logic [44:0] tsh;
  logic [40:0] t_r;
  logic [51:0] qh_prod;
  logic [11:0] qh_r;
  logic [11:0] qh5_r;
  logic [11:0] qh6_r;
  logic [20:0] th_r;
  logic [19:0] tl_r;
  logic [21:0] qh_x1000;
  logic [20:0] rh_full;
  logic [29:0] x0_r;
  logic [60:0] ql_prod;
  logic [19:0] ql_r;
  logic [31:0] qmag;
  logic [31:0] point_nxt;
  logic [31:0] point_r;

  // Signed offset from the principal point as magnitude and sign.
  always_comb begin
    pos = {pix, 8'd0};
    if (pos < center) begin
      neg_nxt = 1'b1;
      mag_nxt = center - pos;
    end else begin
      neg_nxt = 1'b0;
      mag_nxt = pos - center;
    end
  end

  // Rounding offset and the coarse saturation test.
  always_comb begin
    rnd = {1'b0, prod_r} + dpn_pkg::COORD_ROUND;
    tsh = rnd[60:16];
  end

  // Division of the 41-bit value by 1000 in two digits of 21 and 20 bits.
  assign qh_prod  = 52'(t_r[40:20]) * 52'(dpn_pkg::RECIP_1000);
  assign qh_x1000 = 22'(qh_r) * dpn_pkg::DIV_1000;
  assign rh_full  = th_r - qh_x1000[20:0];
  assign ql_prod  = 61'(x0_r) * 61'(dpn_pkg::RECIP_1000);

  // Final sign and clamp.
  always_comb begin
    qmag = {1'b0, qh6_r[10:0], ql_r};
    if (sat_r[dpn_pkg::ST_DIVL]) begin
      point_nxt = neg_r[dpn_pkg::ST_DIVL] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg_r[dpn_pkg::ST_DIVL]) begin
      point_nxt = 32'd0 - qmag;
    end else begin
      point_nxt = qmag;
    end
  end

  // Stage registers, each loaded by its own enable.
  always_ff @(posedge clk) begin
    if (ctl.load[dpn_pkg::ST_IN]) begin
      mag_r                  <= mag_nxt;
      neg_r[dpn_pkg::ST_IN]  <= neg_nxt;
      dep_r                  <= depth;
    end
    if (ctl.load[dpn_pkg::ST_MUL1]) begin
      p1_r                    <= 44'(mag_r) * 44'(inv);
      neg_r[dpn_pkg::ST_MUL1] <= neg_r[dpn_pkg::ST_IN];
      dep1_r                  <= dep_r;
    end
    if (ctl.load[dpn_pkg::ST_MUL2]) begin
      prod_r                  <= 60'(p1_r) * 60'(dep1_r);
      neg_r[dpn_pkg::ST_MUL2] <= neg_r[dpn_pkg::ST_MUL1];
    end
    if (ctl.load[dpn_pkg::ST_RND]) begin
      t_r                    <= tsh[40:0];
      sat_r[dpn_pkg::ST_RND] <= (tsh >= dpn_pkg::SAT_LIM);
      neg_r[dpn_pkg::ST_RND] <= neg_r[dpn_pkg::ST_MUL2];
    end
    if (ctl.load[dpn_pkg::ST_DIVH]) begin
      qh_r                    <= qh_prod[51:40];
      th_r                    <= t_r[40:20];
      tl_r                    <= t_r[19:0];
      sat_r[dpn_pkg::ST_DIVH] <= sat_r[dpn_pkg::ST_RND];
      neg_r[dpn_pkg::ST_DIVH] <= neg_r[dpn_pkg::ST_RND];
    end
    if (ctl.load[dpn_pkg::ST_REMH]) begin
      x0_r                    <= {rh_full[9:0], tl_r};
      qh5_r                   <= qh_r;
      sat_r[dpn_pkg::ST_REMH] <= sat_r[dpn_pkg::ST_DIVH];
      neg_r[dpn_pkg::ST_REMH] <= neg_r[dpn_pkg::ST_DIVH];
    end
    if (ctl.load[dpn_pkg::ST_DIVL]) begin
      ql_r                    <= ql_prod[59:40];
      qh6_r                   <= qh5_r;
      sat_r[dpn_pkg::ST_DIVL] <= sat_r[dpn_pkg::ST_REMH];
      neg_r[dpn_pkg::ST_DIVL] <= neg_r[dpn_pkg::ST_REMH];
    end
    if (ctl.load[dpn_pkg::ST_OUT]) begin
      point_r <= point_nxt;
    end
  end

  assign point = point_r;

endmodule

`default_nettype wire

FILE: rtl/core/dpn_aux.sv
// ============================================================================
// dpn_aux - depth in metres and normal-map decoding
// point_z = floor(depth * 65536 / 1000) and n = round((2c - 255) * 16384 / 255)
// for each colour byte, delayed to line up with the coordinate lanes.
// ============================================================================
`default_nettype none

module dpn_aux (
  input  wire logic                             clk,
  input  wire dpn_pkg::dpn_ctl_t                ctl,
  input  wire logic [dpn_pkg::DEPTH_W-1:0]      depth,
  input  wire logic [dpn_pkg::COLOR_W-1:0]      red,
  input  wire logic [dpn_pkg::COLOR_W-1:0]      green,
  input  wire logic [dpn_pkg::COLOR_W-1:0]      blue,
  output logic [dpn_pkg::Z_W-1:0]               point_z,
  output logic signed [dpn_pkg::NRM_W-1:0]      nrm_x,
  output logic signed [dpn_pkg::NRM_W-1:0]      nrm_y,
  output logic signed [dpn_pkg::NRM_W-1:0]      nrm_z
);

  logic [2:0][7:0]  col;
  logic [2:0][7:0]  nabs_nxt;
  logic [2:0]       nneg_nxt;
  logic [2:0][7:0]  nabs_r;
  logic [2:0]       nneg_r;
  logic [2:0][7:0]  nabs1_r;
  logic [2:0]       nneg1_r;
  logic [2:0][14:0] nv;
  logic [2:0][30:0] nm_r;
  logic [2:0][14:0] nmag;
  logic [2:0][15:0] nrm_nxt;
  logic [48:0]      zp_r;
  logic [2:0][15:0] nrm_r [dpn_pkg::ST_MUL2:dpn_pkg::ST_OUT];
  logic [22:0]      z_r   [dpn_pkg::ST_MUL1:dpn_pkg::ST_OUT];

  assign col = {blue, green, red};

  // Distance of each byte from mid-scale, and the sign of the component.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nneg_nxt[i] = !col[i][7];
      if (col[i][7]) begin
        nabs_nxt[i] = 8'({col[i], 1'b0} - 9'd255);
      end else begin
        nabs_nxt[i] = 8'(9'd255 - {col[i], 1'b0});
      end
    end
  end

  // 16384 / 255 = 64 + 64 / 255: whole part by shift, the rest by reciprocal.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i]   = {1'b0, nabs_r[i], 6'd0} + dpn_pkg::NRM_HALF;
      nmag[i] = {1'b0, nabs1_r[i], 6'd0} + 15'(nm_r[i][30:23]);
      if (nneg1_r[i]) begin
        nrm_nxt[i] = 16'd0 - {1'b0, nmag[i]};
      end else begin
        nrm_nxt[i] = {1'b0, nmag[i]};
      end
    end
  end

  // Front stages: multiplications, then the delay line to the output.
  always_ff @(posedge clk) begin
    if (ctl.load[dpn_pkg::ST_IN]) begin
      zp_r   <= 49'(depth) * 49'(dpn_pkg::Z_RECIP);
      nabs_r <= nabs_nxt;
      nneg_r <= nneg_nxt;
    end
    if (ctl.load[dpn_pkg::ST_MUL1]) begin
      z_r[dpn_pkg::ST_MUL1] <= zp_r[48:26];
      nabs1_r               <= nabs_r;
      nneg1_r               <= nneg_r;
      for (int i = 0; i < 3; i++) begin
        nm_r[i] <= 31'(nv[i]) * 31'(dpn_pkg::NRM_RECIP);
      end
    end
    if (ctl.load[dpn_pkg::ST_MUL2]) begin
      z_r[dpn_pkg::ST_MUL2]   <= z_r[dpn_pkg::ST_MUL1];
      nrm_r[dpn_pkg::ST_MUL2] <= nrm_nxt;
    end
    for (int k = dpn_pkg::ST_RND; k <= dpn_pkg::ST_OUT; k++) begin
      if (ctl.load[k]) begin
        z_r[k]   <= z_r[k-1];
        nrm_r[k] <= nrm_r[k-1];
      end
    end
  end

  assign point_z = z_r[dpn_pkg::ST_OUT];
  assign nrm_x   = nrm_r[dpn_pkg::ST_OUT][0];
  assign nrm_y   = nrm_r[dpn_pkg::ST_OUT][1];
  assign nrm_z   = nrm_r[dpn_pkg::ST_OUT][2];

endmodule

`default_nettype wire

FILE: rtl/core/depth_pixel_to_point_normal_core.sv
// An accepted input beat passes through every pipeline stage register, ST_IN
// to ST_OUT, before its output beat is valid.
// Throughput: one beat per cycle while the output channel does not stall;
// only a stall on the output channel holds the input back.
// A zero-depth beat is accepted and yields no output beat.
// Reset clears all pipeline valid bits and loads the default camera registers.
// ============================================================================
// depth_pixel_to_point_normal_core - pinhole back-projection of depth pixels
// Turns column, row and depth into a Q16.16 point in metres and decodes the
// normal-map colour into three Q2.14 components.
// ============================================================================
`default_nettype none

module depth_pixel_to_point_normal_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input pixel channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [dpn_pkg::PIX_W-1:0]            in_column,
  input  wire logic [dpn_pkg::PIX_W-1:0]            in_row,
  input  wire logic [dpn_pkg::DEPTH_W-1:0]          in_depth_mm,
  input  wire logic [dpn_pkg::COLOR_W-1:0]          in_red,
  input  wire logic [dpn_pkg::COLOR_W-1:0]          in_green,
  input  wire logic [dpn_pkg::COLOR_W-1:0]          in_blue,
  // Output point channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [dpn_pkg::COORD_W-1:0]        out_point_x,
  output logic signed [dpn_pkg::COORD_W-1:0]        out_point_y,
  output logic [dpn_pkg::Z_W-1:0]                   out_point_z,
  output logic signed [dpn_pkg::NRM_W-1:0]          out_normal_x,
  output logic signed [dpn_pkg::NRM_W-1:0]          out_normal_y,
  output logic signed [dpn_pkg::NRM_W-1:0]          out_normal_z,
  // Configuration write channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [dpn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dpn_pkg::CFG_DAT_W-1:0]        cfg_data
);

  logic [dpn_pkg::INV_W-1:0] inv_fx_r;
  logic [dpn_pkg::INV_W-1:0] inv_fy_r;
  logic [dpn_pkg::CTR_W-1:0] ctr_x_r;
  logic [dpn_pkg::CTR_W-1:0] ctr_y_r;
  dpn_pkg::dpn_ctl_t         ctl;

  // Camera registers, written by a configuration beat.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_fx_r <= dpn_pkg::RST_INV_FX;
      inv_fy_r <= dpn_pkg::RST_INV_FY;
      ctr_x_r  <= dpn_pkg::RST_CTR_X;
      ctr_y_r  <= dpn_pkg::RST_CTR_Y;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dpn_pkg::REG_INV_FX: inv_fx_r <= cfg_data[dpn_pkg::INV_W-1:0];
        dpn_pkg::REG_INV_FY: inv_fy_r <= cfg_data[dpn_pkg::INV_W-1:0];
        dpn_pkg::REG_CTR_X:  ctr_x_r  <= cfg_data[dpn_pkg::CTR_W-1:0];
        dpn_pkg::REG_CTR_Y:  ctr_y_r  <= cfg_data[dpn_pkg::CTR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline control.
  dpn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_nz     (|in_depth_mm),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  // Horizontal and vertical coordinate lanes.
  dpn_proj u_proj_x (
    .clk    (clk),
    .ctl    (ctl),
    .pix    (in_column),
    .center (ctr_x_r),
    .inv    (inv_fx_r),
    .depth  (in_depth_mm),
    .point  (out_point_x)
  );

  dpn_proj u_proj_y (
    .clk    (clk),
    .ctl    (ctl),
    .pix    (in_row),
    .center (ctr_y_r),
    .inv    (inv_fy_r),
    .depth  (in_depth_mm),
    .point  (out_point_y)
  );

  // Depth and normal decoding.
  dpn_aux u_aux (
    .clk     (clk),
    .ctl     (ctl),
    .depth   (in_depth_mm),
    .red     (in_red),
    .green   (in_green),
    .blue    (in_blue),
    .point_z (out_point_z),
    .nrm_x   (out_normal_x),
    .nrm_y   (out_normal_y),
    .nrm_z   (out_normal_z)
  );

endmodule

`default_nettype wire
